[hw/rtl/udiv_pkg.sv]
package udiv_pkg;

    // Fixed width of the operand and result ports.
    localparam int FIELD_W = 64;

    // Default operand width inside the divider.
    localparam int DEFAULT_WIDTH = 64;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic divisor_zero;
        logic last;
    } t_status;

endpackage

[hw/rtl/udiv_dpath.sv]
module udiv_dpath #(
    parameter int WIDTH = udiv_pkg::DEFAULT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  udiv_pkg::t_cmd                 i_cmd,
    input  logic [udiv_pkg::FIELD_W-1:0]   i_dividend,
    input  logic [udiv_pkg::FIELD_W-1:0]   i_divisor,
    output udiv_pkg::t_status              o_status,
    output logic [udiv_pkg::FIELD_W-1:0]   o_quotient,
    output logic [udiv_pkg::FIELD_W-1:0]   o_remainder,
    output logic                           o_divide_by_zero
);
    import udiv_pkg::*;

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    // Partial remainder carries one extra bit as its sign.
    logic [WIDTH:0]   r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_den, n_den;
    logic             r_dz,  n_dz;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [WIDTH-1:0] num_in;
    logic [WIDTH-1:0] den_in;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   den_ext;
    logic [WIDTH:0]   step_rem;

    assign num_in  = i_dividend[WIDTH-1:0];
    assign den_in  = i_divisor[WIDTH-1:0];
    assign den_ext = {1'b0, r_den};

    // One non-restoring iteration: shift in the next dividend bit, then add
    // the divisor back if the remainder is negative, else subtract it.
    assign shifted  = {r_rem[WIDTH-1:0], r_quo[WIDTH-1]};
    assign step_rem = r_rem[WIDTH] ? (shifted + den_ext) : (shifted - den_ext);

    // Status for the controller.
    assign o_status.divisor_zero = (den_in == '0);
    assign o_status.last         = (r_cnt == CNT_W'(WIDTH - 1));

    // Next values of the datapath registers.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_den = r_den;
        n_dz  = r_dz;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_den = den_in;
            n_cnt = '0;
            n_dz  = (den_in == '0);
            if (den_in == '0) begin
                // Divide by zero: quotient zero, dividend as remainder.
                n_quo = '0;
                n_rem = {1'b0, num_in};
            end else begin
                n_quo = num_in;
                n_rem = '0;
            end
        end else if (i_cmd.step) begin
            n_rem = step_rem;
            n_quo = {r_quo[WIDTH-2:0], ~step_rem[WIDTH]};
            n_cnt = r_cnt + 1'b1;
        end else if (i_cmd.fix) begin
            // A negative final remainder is restored by one add.
            if (r_rem[WIDTH]) begin
                n_rem = r_rem + den_ext;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_dz  <= n_dz;
    end

    // Iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_quotient       = FIELD_W'(r_quo);
    assign o_remainder      = FIELD_W'(r_rem[WIDTH-1:0]);
    assign o_divide_by_zero = r_dz;

endmodule

[hw/rtl/udiv_ctrl.sv]
module udiv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  udiv_pkg::t_status i_status,
    output udiv_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import udiv_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_cmd.fix  = 1'b0;
        o_busy     = 1'b1;
        o_done     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.divisor_zero ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/unsigned_nonrestoring_divider.sv]
// Unsigned WIDTH-bit divider using radix-2 non-restoring division. A beat is
// accepted when start is high while busy is low; only the low WIDTH bits of
// each operand are used. One adder/subtractor makes one quotient bit per
// cycle; the result appears after WIDTH iterations, a correction step and an
// output step, and busy stays high until the result has been shown, so the
// next beat is taken only after that. A zero divisor skips the iterations:
// the result follows in the next cycle with quotient zero, the dividend as
// remainder and o_divide_by_zero set. The result is shown for exactly one
// cycle with o_done high; the outputs keep it until the next beat is accepted,
// but the receiver cannot stall the block; it must capture it then.
module unsigned_nonrestoring_divider #(
    parameter int WIDTH = udiv_pkg::DEFAULT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [udiv_pkg::FIELD_W-1:0] i_dividend,
    input  logic [udiv_pkg::FIELD_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [udiv_pkg::FIELD_W-1:0] o_quotient,
    output logic [udiv_pkg::FIELD_W-1:0] o_remainder,
    output logic                         o_divide_by_zero
);
    import udiv_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    udiv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // Remainder, quotient and divisor registers with the add/subtract unit.
    udiv_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_status         (status),
        .o_quotient       (o_quotient),
        .o_remainder      (o_remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // The result strobe lasts a single cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // An accepted beat makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a beat");

    // A divide by zero always reports a zero quotient.
    a_dz_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_divide_by_zero |-> o_quotient == '0)
        else $error("nonzero quotient on divide by zero");

    // The strobe is never raised while the block is idle.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

endmodule
